>>> sv/module_fault_enable_supervisor_macros.svh
// assertion macros for the module fault enable supervisor
`ifndef MODULE_FAULT_ENABLE_SUPERVISOR_MACROS_SVH
`define MODULE_FAULT_ENABLE_SUPERVISOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MFES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfes assertion failed");

`define MFES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfes assertion failed");

`else

`define MFES_ASSERT_IMP(lbl, ante, cons)

`define MFES_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> sv/mfes_pkg.sv
// shared types and constants for the module fault enable supervisor
package mfes_pkg;

  localparam int ModulesDef   = 25;
  localparam int FaultBitsDef = 3;

  localparam int MaskW    = 25;
  localparam int CodeW    = 3;
  localparam int IdW      = 5;
  localparam int OpW      = 3;
  localparam int CountW   = 5;
  localparam int CfgIdxW  = 1;
  localparam int CmpW     = 8;

  localparam logic [MaskW-1:0]  CritReset  = MaskW'(15);
  localparam logic [CodeW-1:0]  MdcReset   = CodeW'(1);
  localparam logic [CountW-1:0] CountSat   = {CountW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OP_DISABLE   = 3'd0,
    OP_ENABLE    = 3'd1,
    OP_SET_FAULT = 3'd2,
    OP_CLR_FAULT = 3'd3,
    OP_RESTORE   = 3'd4,
    OP_QUERY     = 3'd5
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CRITICAL_MASK = 1'b0,
    CFG_MANUAL_CODE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_APPLY  = 2'd1,
    ST_SCAN   = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

endpackage

>>> sv/mfes_fault_ram.sv
// fault code store with per-entry valid bits and registered read
module mfes_fault_ram
  import mfes_pkg::*;
#(
  parameter int DEPTH = ModulesDef,
  parameter int WIDTH = FaultBitsDef,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvld_q <= valid_q[raddr_i];
    end
  end

  // an entry never written reads as no fault
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> sv/module_fault_enable_supervisor.sv
// top level: a beat is taken in idle, applied, swept over the fault store, then registered
// no new beat is taken before the last result is loaded; the sweep reads each entry once
// each beat runs accept, apply, sweep and finish states; finish holds while the output stalls
// a finished result waits in the output register while the next beat is taken
// reset: enables all on, fault codes read zero through valid bits, no clearing pass
module module_fault_enable_supervisor
  import mfes_pkg::*;
#(
  parameter int MODULES    = ModulesDef,
  parameter int FAULT_BITS = FaultBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MaskW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic [IdW-1:0]     module_id_i,
  input  logic [CodeW-1:0]   fault_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic               is_critical_o,
  output logic               effective_enable_o,
  output logic [CodeW-1:0]   module_fault_o,
  output logic               should_block_o,
  output logic               critical_fault_present_o,
  output logic [CountW-1:0]  active_noncritical_faults_o,
  output logic [MaskW-1:0]   enabled_mask_o,
  output logic [MaskW-1:0]   fault_mask_o,
  output logic [MaskW-1:0]   disabled_mask_o
);

  `include "module_fault_enable_supervisor_macros.svh"

  localparam int IdxW = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int CntW = $clog2(MODULES + 1);

  state_e state_q, state_d;

  logic [MaskW-1:0]      crit_q;
  logic [CodeW-1:0]      mdc_q;
  logic [MODULES-1:0]    en_q, en_d;
  logic [MODULES-1:0]    crit_vec;

  op_e                   op_q;
  logic [IdW-1:0]        id_q;
  logic [FAULT_BITS-1:0] code_q;
  logic                  acc_q, acc_d;

  logic [CntW-1:0]       cnt_q;
  logic                  rd_pend_q;
  logic [IdxW-1:0]       rd_idx_q;

  logic [MODULES-1:0]    en_acc_q, f_acc_q, d_acc_q;
  logic                  cf_acc_q;
  logic [CountW-1:0]     cnt_acc_q;
  logic [FAULT_BITS-1:0] fc_cap_q;

  logic                  out_valid_q;
  logic                  acc_out_q, crit_out_q, een_out_q, blk_out_q, cf_out_q;
  logic [CodeW-1:0]      fc_out_q;
  logic [CountW-1:0]     cnt_out_q;
  logic [MaskW-1:0]      en_m_q, f_m_q, d_m_q;

  logic                  in_acc, out_acc, load_out;
  logic                  id_valid;
  logic [IdxW-1:0]       id_idx;
  logic                  issue;
  logic [IdxW-1:0]       raddr;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [FAULT_BITS-1:0] wdata;
  logic [FAULT_BITS-1:0] rdata;
  logic                  restore_hit;
  logic [FAULT_BITS-1:0] eff_code;
  logic                  sc_crit, sc_en, sc_flt;

  genvar g;
  for (g = 0; g < MODULES; g++) begin : g_crit
    if (g < MaskW) begin : g_in
      assign crit_vec[g] = crit_q[g];
    end else begin : g_out
      assign crit_vec[g] = 1'b0;
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign id_valid = {1'b0, id_q} < (IdW + 1)'(MODULES);
  assign id_idx   = id_q[IdxW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_SCAN;
      ST_SCAN:   if (cnt_q == CntW'(MODULES)) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_APPLY:  ;
      ST_SCAN:   issue = cnt_q < CntW'(MODULES);
      ST_FINISH: load_out = !out_valid_q || !out_stall_i;
      default:   ;
    endcase
  end

  // apply step: enable bits and accepted flag
  always_comb begin
    en_d  = en_q;
    acc_d = 1'b0;
    unique case (op_q)
      OP_DISABLE: begin
        if (id_valid && !crit_vec[id_idx]) begin
          en_d[id_idx] = 1'b0;
          acc_d        = 1'b1;
        end
      end
      OP_ENABLE: begin
        if (id_valid) begin
          en_d[id_idx] = 1'b1;
          acc_d        = 1'b1;
        end
      end
      OP_SET_FAULT, OP_CLR_FAULT, OP_QUERY: acc_d = id_valid;
      OP_RESTORE: begin
        en_d  = '1;
        acc_d = 1'b1;
      end
      default: acc_d = 1'b0;
    endcase
  end

  // per-module evaluation on the returning read beat
  assign restore_hit = (op_q == OP_RESTORE) && (CmpW'(rdata) == CmpW'(mdc_q));
  assign eff_code    = restore_hit ? '0 : rdata;
  assign sc_crit     = crit_vec[rd_idx_q];
  assign sc_en       = en_q[rd_idx_q];
  assign sc_flt      = eff_code != '0;

  // fault store port muxing
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx_q;
    wdata = '0;
    if (state_q == ST_APPLY) begin
      waddr = id_idx;
      wdata = (op_q == OP_SET_FAULT) ? code_q : '0;
      we    = id_valid && ((op_q == OP_SET_FAULT) || (op_q == OP_CLR_FAULT));
    end else if (rd_pend_q) begin
      we = restore_hit;
    end
  end

  assign raddr = issue ? cnt_q[IdxW-1:0] : '0;

  mfes_fault_ram #(
    .DEPTH(MODULES),
    .WIDTH(FAULT_BITS)
  ) u_fault_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      crit_q      <= CritReset;
      mdc_q       <= MdcReset;
      en_q        <= '1;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= issue;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CRITICAL_MASK: crit_q <= cfg_wdata_i;
          CFG_MANUAL_CODE:   mdc_q  <= cfg_wdata_i[CodeW-1:0];
          default:           ;
        endcase
      end
      if (state_q == ST_APPLY) begin
        en_q  <= en_d;
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(operation_i);
      id_q   <= module_id_i;
      code_q <= FAULT_BITS'(fault_code_i);
    end
    if (issue) begin
      rd_idx_q <= cnt_q[IdxW-1:0];
    end
    if (state_q == ST_APPLY) begin
      acc_q     <= acc_d;
      en_acc_q  <= '0;
      f_acc_q   <= '0;
      d_acc_q   <= '0;
      cf_acc_q  <= 1'b0;
      cnt_acc_q <= '0;
      fc_cap_q  <= '0;
    end else if (rd_pend_q) begin
      en_acc_q[rd_idx_q] <= sc_crit || sc_en;
      f_acc_q[rd_idx_q]  <= sc_flt;
      d_acc_q[rd_idx_q]  <= !sc_crit && !sc_en;
      if (sc_crit && sc_flt) begin
        cf_acc_q <= 1'b1;
      end
      if (!sc_crit && sc_flt && sc_en && (cnt_acc_q != CountSat)) begin
        cnt_acc_q <= cnt_acc_q + CountW'(1);
      end
      if (rd_idx_q == id_idx) begin
        fc_cap_q <= eff_code;
      end
    end
    if (load_out) begin
      acc_out_q <= acc_q;
      cf_out_q  <= cf_acc_q;
      cnt_out_q <= cnt_acc_q;
      en_m_q    <= MaskW'(en_acc_q);
      f_m_q     <= MaskW'(f_acc_q);
      d_m_q     <= MaskW'(d_acc_q);
      if (id_valid) begin
        crit_out_q <= crit_vec[id_idx];
        een_out_q  <= crit_vec[id_idx] || en_q[id_idx];
        fc_out_q   <= CodeW'(fc_cap_q);
        blk_out_q  <= (fc_cap_q != '0) && (crit_vec[id_idx] || en_q[id_idx]);
      end else begin
        crit_out_q <= 1'b1;
        een_out_q  <= 1'b0;
        fc_out_q   <= '0;
        blk_out_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o                 = out_valid_q;
  assign accepted_o                  = acc_out_q;
  assign is_critical_o               = crit_out_q;
  assign effective_enable_o          = een_out_q;
  assign module_fault_o              = fc_out_q;
  assign should_block_o              = blk_out_q;
  assign critical_fault_present_o    = cf_out_q;
  assign active_noncritical_faults_o = cnt_out_q;
  assign enabled_mask_o              = en_m_q;
  assign fault_mask_o                = f_m_q;
  assign disabled_mask_o             = d_m_q;

  `MFES_ASSERT_NXT(a_accept_to_apply, in_acc, state_q == ST_APPLY)
  `MFES_ASSERT_NXT(a_scan_ends, (state_q == ST_SCAN) && (cnt_q == CntW'(MODULES)),
                   state_q == ST_FINISH)
  `MFES_ASSERT_IMP(a_read_in_scan, rd_pend_q, $past(state_q) == ST_SCAN)
  `MFES_ASSERT_IMP(a_masks_disjoint, out_valid_o, (enabled_mask_o & disabled_mask_o) == '0)

endmodule
